@@ src/srrc_pkg.sv @@
// Shared types, widths and constants of the stepper rate ramp controller.
`timescale 1ns / 1ps

package srrc_pkg;

  // Field widths.
  localparam int RATE_W      = 14;
  localparam int HZ_W        = 16;
  localparam int COUNT_W     = 31;
  localparam int WRAP_W      = 16;
  localparam int LEVEL_W     = 15;
  localparam int RAMP_LEN_W  = 20;
  localparam int TICK_W      = 10;
  localparam int PHASE_W     = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  // Defaults of the ramp shape.
  localparam int RATE_INCREMENT_DEF      = 16;
  localparam int TICKS_PER_INCREMENT_DEF = 1000;

  // Rate limits and register reset values.
  localparam logic [RATE_W-1:0] LOW_HZ           = 14'd8;
  localparam logic [RATE_W-1:0] HIGH_HZ          = 14'd16000;
  localparam logic [RATE_W-1:0] MAX_RATE_RESET   = 14'd16000;
  localparam logic [RATE_W-1:0] RAMP_START_RESET = 14'd15960;

  // Wrap formula: TOP_WRAP - ceil((rate - 8) * SLOPE_NUM / SLOPE_DEN).
  localparam logic [WRAP_W-1:0] TOP_WRAP = 16'd62500;
  localparam logic [WRAP_W-1:0] MIN_WRAP = 16'd31;
  localparam int SLOPE_NUM_W = 18;
  localparam logic [SLOPE_NUM_W-1:0] SLOPE_NUM = 18'd249875;
  localparam int SLOPE_DEN   = 63968;
  localparam int PROD_X_W    = 32;
  localparam logic [PROD_X_W-1:0] DEN_BIAS = 32'(SLOPE_DEN - 1);
  // SLOPE_DEN is 32 times an odd number; the odd part is divided by reciprocal.
  localparam int DEN_SHIFT   = 5;
  localparam int DEN_ODD     = SLOPE_DEN / (2 ** DEN_SHIFT);
  localparam int QUOT_IN_W   = PROD_X_W - DEN_SHIFT;
  localparam int RECIP_SHIFT = QUOT_IN_W + 11;
  localparam int WRAP_RECIP_W = 28;
  localparam logic [WRAP_RECIP_W-1:0] WRAP_RECIP =
    28'(((64'd1 << RECIP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
  localparam int PROD_Y_W    = QUOT_IN_W + WRAP_RECIP_W;

  // Operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_START = 1'd1;

  // Ramp phase codes.
  localparam logic [PHASE_W-1:0] PHASE_STEADY = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_UP     = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DOWN   = 2'd2;

  typedef struct packed {
    logic               op;
    logic [HZ_W-1:0]    rate_hz;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic [WRAP_W-1:0]  period_wrap;
    logic [LEVEL_W-1:0] compare_level;
    logic               pwm_running;
    logic               driver_disable;
    logic [COUNT_W-1:0] steps_left;
    logic [RATE_W-1:0]  current_rate;
    logic [PHASE_W-1:0] ramp_phase;
    logic               rate_rejected;
  } result_t;

endpackage

@@ src/stepper_rate_ramp_controller.sv @@
// Stepper rate controller with trapezoidal ramp and PWM period computation.
`timescale 1ns / 1ps

// Usage
// The item channel (item_valid, item_ready, item) takes one word per step
// tick or move command. A move command loads a microstep count and a rate;
// a step tick counts one microstep down and steps the ramp. Every accepted
// word gives exactly one result word on the result channel (result_valid,
// result_ready, result) with the PWM wrap, compare level and controller status.
// The cfg channel writes max_rate_hz (index 0) and ramp_start_hz (index 1);
// cfg_ready is always high; the user must write only while idle (not checked).
// Pipeline: a word passes through the input register, state update, rate
// product, reciprocal product and output register stages before its result.
// Throughput: one word per cycle while result_ready stays high. Controller
// state is updated as a word leaves the input register, so back-to-back words
// see each other's effects; the wrap arithmetic follows in two multiplier stages.
// Each stage holds its word while the next one is full, so a stalled receiver
// fills the pipeline and then drops item_ready; bubbles are squeezed out.
// Reset (rst, synchronous) empties the pipeline, restores both registers to
// 16000 and 15960 Hz, stops the motor (PWM off, driver disabled) and clears
// the count and the ramp.

module stepper_rate_ramp_controller import srrc_pkg::*; #(
  parameter int RATE_INCREMENT      = RATE_INCREMENT_DEF,
  parameter int TICKS_PER_INCREMENT = TICKS_PER_INCREMENT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Rate step and its exact reciprocal for dividing a 14-bit rate span.
  localparam int RI_W     = $clog2(RATE_INCREMENT + 1);
  localparam int RI_LOG   = $clog2(RATE_INCREMENT);
  localparam int Q_SHIFT  = RATE_W + RI_LOG;
  localparam int RECIP_W  = RATE_W + 1;
  localparam int QPROD_W  = RATE_W + RECIP_W;
  localparam logic [RI_W-1:0] RI_STEP = RI_W'(RATE_INCREMENT);
  localparam logic [RECIP_W-1:0] RI_RECIP =
    RECIP_W'(((64'd1 << Q_SHIFT) + 64'(RATE_INCREMENT) - 64'd1) / 64'(RATE_INCREMENT));
  localparam logic [TICK_W-1:0] TICK_RELOAD = TICK_W'(TICKS_PER_INCREMENT);
  localparam int LPROD_W = RATE_W + TICK_W + 1;
  localparam logic [LPROD_W-1:0] RAMP_LEN_SAT = LPROD_W'({RAMP_LEN_W{1'b1}});

  typedef struct packed {
    logic               pwm_running;
    logic               driver_disable;
    logic [COUNT_W-1:0] steps_left;
    logic [RATE_W-1:0]  current_rate;
    logic [PHASE_W-1:0] ramp_phase;
    logic               rate_rejected;
  } status_t;

  // Configuration registers.
  logic [RATE_W-1:0] max_rate_hz;
  logic [RATE_W-1:0] ramp_start_hz;

  // Controller state. The ramp length is kept as its quotient part; the
  // length itself is rebuilt from it when a tick compares against it.
  logic [COUNT_W-1:0] remaining_steps;
  logic [RATE_W-1:0]  rate_now;
  logic [RATE_W-1:0]  rate_goal;
  logic [RATE_W-1:0]  ramp_quot;
  logic               ramp_on;
  logic [TICK_W-1:0]  tick_countdown;
  logic               going_up;
  logic               going_down;
  logic               pwm_enabled;
  logic               driver_off;

  // Pipeline registers.
  logic                  s0_valid;
  item_t                 s0_item;
  logic                  s1_valid;
  status_t               s1_status;
  logic [RATE_W-1:0]     s1_rate_off;
  logic                  s2_valid;
  status_t               s2_status;
  logic [PROD_X_W-1:0]   s2_x;
  logic                  s3_valid;
  status_t               s3_status;
  logic [PROD_Y_W-1:0]   s3_p;

  // Flow control: a stage may load when it is empty or its word moves on.
  logic out_free, s3_free, s2_free, s1_free, s0_free, s0_go;

  assign out_free   = !result_valid || result_ready;
  assign s3_free    = !s3_valid || out_free;
  assign s2_free    = !s2_valid || s3_free;
  assign s1_free    = !s1_valid || s2_free;
  assign s0_free    = !s0_valid || s1_free;
  assign s0_go      = s0_valid && s1_free;
  assign item_ready = s0_free;
  assign cfg_ready  = 1'b1;

  // Next state for the word in the input register.
  logic [RATE_W-1:0]     top_hz, hz_cl, start_eff;
  logic                  rejected;
  logic [RATE_W-1:0]     rate_span;
  logic [QPROD_W-1:0]    quot_prod;
  logic [LPROD_W-1:0]    len_full;
  logic [RAMP_LEN_W-1:0] ramp_len;
  logic [TICK_W-1:0]     tc_dec;
  logic [RATE_W:0]       rate_sum;
  logic [RATE_W-1:0]     rate_held;

  logic [COUNT_W-1:0] remaining_steps_next;
  logic [RATE_W-1:0]  rate_now_next;
  logic [RATE_W-1:0]  rate_goal_next;
  logic [RATE_W-1:0]  ramp_quot_next;
  logic               ramp_on_next;
  logic [TICK_W-1:0]  tick_countdown_next;
  logic               going_up_next;
  logic               going_down_next;
  logic               pwm_enabled_next;
  logic               driver_off_next;
  status_t            s1_status_next;

  always_comb begin
    top_hz = (max_rate_hz > HIGH_HZ) ? HIGH_HZ : max_rate_hz;
    hz_cl  = (s0_item.rate_hz > HZ_W'(top_hz)) ? top_hz : s0_item.rate_hz[RATE_W-1:0];
    if (ramp_start_hz < LOW_HZ) begin
      start_eff = LOW_HZ;
    end else if (ramp_start_hz > HIGH_HZ) begin
      start_eff = HIGH_HZ;
    end else begin
      start_eff = ramp_start_hz;
    end
    rejected  = (s0_item.op == OP_MOVE) && (hz_cl < LOW_HZ);
    rate_span = hz_cl - start_eff;
    quot_prod = QPROD_W'(rate_span) * QPROD_W'(RI_RECIP);
    len_full  = LPROD_W'(ramp_quot) * LPROD_W'(TICK_RELOAD) + LPROD_W'(1);
    if (!ramp_on) begin
      ramp_len = '0;
    end else if (len_full > RAMP_LEN_SAT) begin
      ramp_len = '1;
    end else begin
      ramp_len = len_full[RAMP_LEN_W-1:0];
    end

    remaining_steps_next = remaining_steps;
    rate_now_next        = rate_now;
    rate_goal_next       = rate_goal;
    ramp_quot_next       = ramp_quot;
    ramp_on_next         = ramp_on;
    tick_countdown_next  = tick_countdown;
    going_up_next        = going_up;
    going_down_next      = going_down;
    pwm_enabled_next     = pwm_enabled;
    driver_off_next      = driver_off;
    tc_dec               = '0;
    rate_sum             = '0;

    if (s0_item.op == OP_MOVE) begin
      if (!rejected) begin
        remaining_steps_next = s0_item.count;
        going_down_next      = 1'b0;
        rate_goal_next       = hz_cl;
        if (hz_cl >= start_eff) begin
          rate_now_next       = start_eff;
          ramp_quot_next      = RATE_W'(quot_prod >> Q_SHIFT);
          ramp_on_next        = 1'b1;
          tick_countdown_next = TICK_RELOAD;
          going_up_next       = 1'b1;
        end else begin
          rate_now_next = hz_cl;
          ramp_on_next  = 1'b0;
          going_up_next = 1'b0;
        end
        pwm_enabled_next = 1'b1;
        driver_off_next  = 1'b0;
      end
    end else begin
      // A tick at zero count stops the motor; the count never wraps.
      if (remaining_steps == '0) begin
        pwm_enabled_next = 1'b0;
        driver_off_next  = 1'b1;
      end else begin
        remaining_steps_next = remaining_steps - COUNT_W'(1);
      end
      // Enter ramp down once the remaining count drops inside the ramp.
      if ((remaining_steps_next < COUNT_W'(ramp_len)) && !going_down) begin
        going_down_next     = 1'b1;
        going_up_next       = 1'b0;
        tick_countdown_next = TICK_RELOAD;
      end
      tc_dec = tick_countdown_next - TICK_W'(1);
      if (going_down_next) begin
        if (tc_dec == '0) begin
          tick_countdown_next = TICK_RELOAD;
          if ((RATE_W+1)'(rate_now) < (RATE_W+1)'(start_eff) + (RATE_W+1)'(RI_STEP)) begin
            rate_now_next   = start_eff;
            going_down_next = 1'b0;
          end else begin
            rate_now_next = rate_now - RATE_W'(RI_STEP);
          end
        end else begin
          tick_countdown_next = tc_dec;
        end
      end else if (going_up_next) begin
        if (tc_dec == '0) begin
          tick_countdown_next = TICK_RELOAD;
          rate_sum = (RATE_W+1)'(rate_now) + (RATE_W+1)'(RI_STEP);
          if (rate_sum >= (RATE_W+1)'(rate_goal)) begin
            rate_now_next = rate_goal;
            going_up_next = 1'b0;
          end else begin
            rate_now_next = rate_sum[RATE_W-1:0];
          end
        end else begin
          tick_countdown_next = tc_dec;
        end
      end
    end

    if (rate_now_next < LOW_HZ) begin
      rate_held = LOW_HZ;
    end else if (rate_now_next > HIGH_HZ) begin
      rate_held = HIGH_HZ;
    end else begin
      rate_held = rate_now_next;
    end

    s1_status_next.pwm_running    = pwm_enabled_next;
    s1_status_next.driver_disable = driver_off_next;
    s1_status_next.steps_left     = remaining_steps_next;
    s1_status_next.current_rate   = rate_now_next;
    s1_status_next.ramp_phase     = going_down_next ? PHASE_DOWN :
                                    (going_up_next ? PHASE_UP : PHASE_STEADY);
    s1_status_next.rate_rejected  = rejected;
  end

  // Wrap arithmetic: ceil(x / SLOPE_DEN) = floor((x + SLOPE_DEN - 1) / SLOPE_DEN),
  // done as a 5-bit shift and an exact reciprocal product for the odd part.
  logic [PROD_X_W-1:0]  x_biased;
  logic [QUOT_IN_W-1:0] quot_in;
  logic [WRAP_W-1:0]    wrap_quot;
  logic [WRAP_W-1:0]    wrap_val;

  assign x_biased  = s2_x + DEN_BIAS;
  assign quot_in   = x_biased[PROD_X_W-1:DEN_SHIFT];
  assign wrap_quot = WRAP_W'(s3_p >> RECIP_SHIFT);
  assign wrap_val  = TOP_WRAP - wrap_quot;

  // Control state, configuration and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate_hz     <= MAX_RATE_RESET;
      ramp_start_hz   <= RAMP_START_RESET;
      remaining_steps <= '0;
      rate_now        <= '0;
      rate_goal       <= '0;
      ramp_quot       <= '0;
      ramp_on         <= 1'b0;
      tick_countdown  <= '0;
      going_up        <= 1'b0;
      going_down      <= 1'b0;
      pwm_enabled     <= 1'b0;
      driver_off      <= 1'b1;
      s0_valid        <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_RATE:   max_rate_hz   <= cfg_data;
          REG_RAMP_START: ramp_start_hz <= cfg_data;
          default: ;
        endcase
      end
      if (s0_go) begin
        remaining_steps <= remaining_steps_next;
        rate_now        <= rate_now_next;
        rate_goal       <= rate_goal_next;
        ramp_quot       <= ramp_quot_next;
        ramp_on         <= ramp_on_next;
        tick_countdown  <= tick_countdown_next;
        going_up        <= going_up_next;
        going_down      <= going_down_next;
        pwm_enabled     <= pwm_enabled_next;
        driver_off      <= driver_off_next;
      end
      if (s0_free)  s0_valid     <= item_valid;
      if (s1_free)  s1_valid     <= s0_valid;
      if (s2_free)  s2_valid     <= s1_valid;
      if (s3_free)  s3_valid     <= s2_valid;
      if (out_free) result_valid <= s3_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_valid && s0_free) begin
      s0_item <= item;
    end
    if (s0_go) begin
      s1_status   <= s1_status_next;
      s1_rate_off <= rate_held - LOW_HZ;
    end
    if (s1_valid && s2_free) begin
      s2_status <= s1_status;
      s2_x      <= PROD_X_W'(s1_rate_off) * PROD_X_W'(SLOPE_NUM);
    end
    if (s2_valid && s3_free) begin
      s3_status <= s2_status;
      s3_p      <= PROD_Y_W'(quot_in) * PROD_Y_W'(WRAP_RECIP);
    end
    if (s3_valid && out_free) begin
      result.period_wrap    <= wrap_val;
      result.compare_level  <= wrap_val[WRAP_W-1:1];
      result.pwm_running    <= s3_status.pwm_running;
      result.driver_disable <= s3_status.driver_disable;
      result.steps_left     <= s3_status.steps_left;
      result.current_rate   <= s3_status.current_rate;
      result.ramp_phase     <= s3_status.ramp_phase;
      result.rate_rejected  <= s3_status.rate_rejected;
    end
  end

  // The ramp runs in one direction at a time.
  assert property (@(posedge clk) disable iff (rst) !(going_up && going_down))
    else $error("ramp up and ramp down active together");

  // The PWM and the driver are switched together.
  assert property (@(posedge clk) disable iff (rst) pwm_enabled != driver_off)
    else $error("PWM enable and driver disable out of step");

  // A tick with no steps left stops the motor.
  assert property (@(posedge clk) disable iff (rst)
      s0_go && (s0_item.op == OP_TICK) && (remaining_steps == '0)
      |=> !pwm_enabled && driver_off && (remaining_steps == '0))
    else $error("tick at zero count did not stop the motor");

  // The reciprocal division keeps the wrap in MIN_WRAP..TOP_WRAP; rate <= HIGH_HZ.
  assert property (@(posedge clk) disable iff (rst)
      result_valid |-> (result.period_wrap >= MIN_WRAP) && (result.period_wrap <= TOP_WRAP)
                       && (rate_now <= HIGH_HZ))
    else $error("period wrap or rate out of range");

endmodule

@@ tb/ramp_status_checker.sv @@
// Checker that predicts and compares every status word of the stepper rate ramp controller.
`timescale 1ns / 1ps

module ramp_status_checker import srrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     words_due
);

  localparam int unsigned RAMP_LEN_MAX = (1 << RAMP_LEN_W) - 1;
  localparam int ERROR_PRINT_CAP = 200;

  // Shadow copy of the controller state and its two registers.
  logic [COUNT_W-1:0]    steps_to_go;
  logic [RATE_W-1:0]     rate_cur;
  logic [RATE_W-1:0]     rate_target;
  logic [RAMP_LEN_W-1:0] ramp_len;
  logic [TICK_W-1:0]     tick_left;
  logic                  rising;
  logic                  falling;
  logic                  pwm_on;
  logic                  drv_off;
  logic [CFG_DATA_W-1:0] max_rate_reg;
  logic [CFG_DATA_W-1:0] ramp_start_reg;

  result_t status_due[$];
  result_t due_word;
  int fail_count = 0;

  function automatic int unsigned hold_rate(input int unsigned hz);
    if (hz < LOW_HZ) return LOW_HZ;
    if (hz > HIGH_HZ) return HIGH_HZ;
    return hz;
  endfunction

  function automatic logic [WRAP_W-1:0] wrap_for(input logic [RATE_W-1:0] hz);
    longint unsigned span;
    longint unsigned drop;
    span = hold_rate(hz) - LOW_HZ;
    drop = (span * SLOPE_NUM + SLOPE_DEN - 1) / SLOPE_DEN;
    return WRAP_W'(TOP_WRAP - drop);
  endfunction

  // One ramp step is due every time the countdown wraps to zero.
  function automatic bit countdown_done();
    tick_left = tick_left - 1'b1;
    if (tick_left != '0) return 1'b0;
    tick_left = TICK_W'(TICKS_PER_INCREMENT_DEF);
    return 1'b1;
  endfunction

  task automatic clear_controller();
    steps_to_go    = '0;
    rate_cur       = '0;
    rate_target    = '0;
    ramp_len       = '0;
    tick_left      = '0;
    rising         = 1'b0;
    falling        = 1'b0;
    pwm_on         = 1'b0;
    drv_off        = 1'b1;
    max_rate_reg   = MAX_RATE_RESET;
    ramp_start_reg = RAMP_START_RESET;
  endtask

  task automatic advance_controller(input item_t w, output result_t status);
    int unsigned hz;
    int unsigned top;
    int unsigned start;
    int unsigned span;
    logic rejected;
    logic [WRAP_W-1:0] wrap;
    rejected = 1'b0;
    if (w.op == OP_MOVE) begin
      hz = w.rate_hz;
      top = (max_rate_reg > HIGH_HZ) ? HIGH_HZ : max_rate_reg;
      if (hz > top) hz = top;
      if (hz < LOW_HZ) begin
        rejected = 1'b1;
      end else begin
        start = hold_rate(ramp_start_reg);
        steps_to_go = w.count;
        falling = 1'b0;
        rate_target = RATE_W'(hz);
        if (hz >= start) begin
          span = (hz - start) / RATE_INCREMENT_DEF * TICKS_PER_INCREMENT_DEF + 1;
          rate_cur = RATE_W'(start);
          ramp_len = (span > RAMP_LEN_MAX) ? RAMP_LEN_W'(RAMP_LEN_MAX) : RAMP_LEN_W'(span);
          tick_left = TICK_W'(TICKS_PER_INCREMENT_DEF);
          rising = 1'b1;
        end else begin
          rate_cur = RATE_W'(hz);
          ramp_len = '0;
          rising = 1'b0;
        end
        pwm_on = 1'b1;
        drv_off = 1'b0;
      end
    end else begin
      if (steps_to_go == '0) begin
        pwm_on = 1'b0;
        drv_off = 1'b1;
      end else begin
        steps_to_go = steps_to_go - 1'b1;
      end
      if (steps_to_go < COUNT_W'(ramp_len) && !falling) begin
        falling = 1'b1;
        rising = 1'b0;
        tick_left = TICK_W'(TICKS_PER_INCREMENT_DEF);
      end
      if (falling) begin
        if (countdown_done()) begin
          start = hold_rate(ramp_start_reg);
          if (rate_cur < start + RATE_INCREMENT_DEF) begin
            rate_cur = RATE_W'(start);
            falling = 1'b0;
          end else begin
            rate_cur = rate_cur - RATE_W'(RATE_INCREMENT_DEF);
          end
        end
      end
      if (rising) begin
        if (countdown_done()) begin
          rate_cur = rate_cur + RATE_W'(RATE_INCREMENT_DEF);
          if (rate_cur >= rate_target) begin
            rate_cur = rate_target;
            rising = 1'b0;
          end
        end
      end
    end
    wrap = wrap_for(rate_cur);
    status.period_wrap    = wrap;
    status.compare_level  = LEVEL_W'(wrap >> 1);
    status.pwm_running    = pwm_on;
    status.driver_disable = drv_off;
    status.steps_left     = steps_to_go;
    status.current_rate   = rate_cur;
    status.ramp_phase     = falling ? PHASE_DOWN : (rising ? PHASE_UP : PHASE_STEADY);
    status.rate_rejected  = rejected;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= ERROR_PRINT_CAP) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  initial clear_controller();

  always @(posedge clk) begin
    if (rst) begin
      clear_controller();
      status_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ERROR_PRINT_CAP) begin
            $error("result word arrived with no expectation waiting");
          end
        end else begin
          due_word = status_due.pop_front();
          check_field("period_wrap", due_word.period_wrap, result.period_wrap);
          check_field("compare_level", due_word.compare_level, result.compare_level);
          check_field("pwm_running", due_word.pwm_running, result.pwm_running);
          check_field("driver_disable", due_word.driver_disable, result.driver_disable);
          check_field("steps_left", due_word.steps_left, result.steps_left);
          check_field("current_rate", due_word.current_rate, result.current_rate);
          check_field("ramp_phase", due_word.ramp_phase, result.ramp_phase);
          check_field("rate_rejected", due_word.rate_rejected, result.rate_rejected);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_RATE:   max_rate_reg = cfg_data;
          REG_RAMP_START: ramp_start_reg = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        advance_controller(item, due_word);
        status_due.push_back(due_word);
      end
    end
    mismatches <= fail_count;
    words_due <= status_due.size();
  end

endmodule

@@ tb/stepper_rate_ramp_controller_tb.sv @@
// Testbench top: drives step ticks, move commands and register writes, and gives the verdict.
`timescale 1ns / 1ps

module stepper_rate_ramp_controller_tb;
  import srrc_pkg::*;

  // The limit only catches a hang.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles allowed after the last expected word before a register write or the verdict.
  // This leaves margin for a stray word to show up after the pipeline drains.
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_SETTING = 150;
  localparam int NUM_SETTINGS = 7;

  // The receiver switches between these stall patterns at random intervals.
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} sink_mode_e;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MAX_RATE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     words_due;

  int         cycle_count = 0;
  int         burst_left = 0;
  sink_mode_e sink_mode = READY_ALWAYS;
  int         sink_left = 0;

  // Register settings for the random part: reset values, all-ones and all-zeros extremes
  // (out of range on purpose), the slowest legal rate, the widest span, two random pairs.
  logic [CFG_DATA_W-1:0] limit_max [NUM_SETTINGS];
  logic [CFG_DATA_W-1:0] limit_start [NUM_SETTINGS];

  stepper_rate_ramp_controller dut (.*);

  ramp_status_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang guard. A correct run finishes far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stepper_rate_ramp_controller_tb: done, errors");
      $finish;
    end
  end

  // Result side back-pressure. Each pattern holds for a random stretch, so long
  // stalls, coin-flip stalls and stretches with no stall at all all occur while
  // the pipeline is at any fill level.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_left = $urandom_range(1, 60);
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      READY_ALWAYS: result_ready <= 1'b1;
      READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
      default:      result_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // A step tick ignores rate and count, so those carry random bits to show that.
  function automatic item_t tick_word();
    item_t w;
    w.op      = OP_TICK;
    w.rate_hz = HZ_W'($urandom());
    w.count   = COUNT_W'($urandom());
    return w;
  endfunction

  function automatic item_t move_word(input int unsigned hz, input logic [COUNT_W-1:0] steps);
    item_t w;
    w.op      = OP_MOVE;
    w.rate_hz = HZ_W'(hz);
    w.count   = steps;
    return w;
  endfunction

  // Sends one word. Words go out in bursts of random length, and valid drops
  // between bursts. Inside a burst valid stays high from word to word
  // and only the payload changes, so valid is never lowered and raised in one step.
  task automatic send_word(input item_t w);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left = burst_left - 1;
    if (burst_left == 0) item_valid <= 1'b0;
  endtask

  // Ends any open burst and waits until every predicted word has come back.
  // The checker updates its count at each edge, so the value read here always
  // reflects all handshakes up to the previous edge.
  task automatic drain();
    if (burst_left != 0) item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; valid stays high across the two words.
  task automatic write_limits(input logic [CFG_DATA_W-1:0] max_hz,
                              input logic [CFG_DATA_W-1:0] start_hz);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_RATE;
    cfg_data <= max_hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_RAMP_START;
    cfg_data <= start_hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random moves: a command followed by a run of ticks. Rates cluster around the
  // ramp start so that short ramps, one-tick ramps and direct rates all occur; a
  // few are rejected as too slow or land far above the clamp. Most counts are
  // small enough that the run reaches zero and the motor is stopped. A few
  // sequences are stray ticks with no fresh command, and a command with no ticks
  // after it is simply cut short by the next one.
  task automatic run_moves(input int n_words, input int unsigned start_reg);
    int unsigned start;
    int unsigned hz;
    int unsigned pick;
    int          ticks;
    int          sent;
    logic [COUNT_W-1:0] steps;
    start = (start_reg < LOW_HZ) ? LOW_HZ : ((start_reg > HIGH_HZ) ? HIGH_HZ : start_reg);
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick >= 8) begin
        if (pick < 16) hz = $urandom_range(0, LOW_HZ - 1);
        else if (pick < 34) hz = $urandom_range(LOW_HZ, start);
        else if (pick < 46) hz = start;
        else if (pick < 78) hz = start + $urandom_range(0, 80);
        else hz = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 10) steps = '0;
        else if (pick < 78) steps = COUNT_W'($urandom_range(1, 40));
        else if (pick < 92) steps = COUNT_W'($urandom_range(41, 400));
        else if (pick < 97) steps = COUNT_W'($urandom());
        else steps = '1;
        send_word(move_word(hz, steps));
        sent++;
      end else begin
        steps = COUNT_W'($urandom_range(0, 20));
      end
      ticks = $urandom_range(0, ((steps > 120) ? 120 : int'(steps)) + 4);
      repeat (ticks) begin
        send_word(tick_word());
        sent++;
      end
    end
  endtask

  initial begin
    limit_max   = '{MAX_RATE_RESET, 14'd16383, 14'd0, 14'd8, 14'd16000, 14'd0, 14'd0};
    limit_start = '{RAMP_START_RESET, 14'd0, 14'd16383, 14'd8, 14'd8, 14'd0, 14'd0};
    limit_max[5]   = $urandom_range(LOW_HZ, HIGH_HZ);
    limit_start[5] = $urandom_range(LOW_HZ, HIGH_HZ);
    limit_max[6]   = $urandom_range(LOW_HZ, HIGH_HZ);
    limit_start[6] = $urandom_range(LOW_HZ, HIGH_HZ);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words with the registers at their reset values (ramp start 15960).
    // A tick straight after reset: rate zero is held to the slowest wrap, count is zero.
    send_word(tick_word());
    // Rates of zero and just under the minimum are rejected and change nothing.
    send_word(move_word(0, 31'd5));
    send_word(move_word(LOW_HZ - 1, 31'd5));
    // The slowest accepted rate, set directly, with nothing to move.
    send_word(move_word(LOW_HZ, '0));
    // A tick at count zero stops the PWM and disables the driver.
    send_word(tick_word());
    // The largest rate is clamped; the full count starts a two-increment ramp.
    send_word(move_word(16'hFFFF, '1));
    repeat (3) send_word(tick_word());
    // Exactly at the ramp start: a ramp of length one, which turns down at the end.
    send_word(move_word(RAMP_START_RESET, 31'd3));
    repeat (5) send_word(tick_word());
    // Just below the ramp start: direct rate, no ramp.
    send_word(move_word(RAMP_START_RESET - 1, 31'd1));
    repeat (2) send_word(tick_word());
    // Alternating bit patterns in both command fields, back to back.
    send_word(move_word(16'hAAAA, 31'h2AAA_AAAA));
    send_word(move_word(16'h5555, 31'h5555_5555));
    send_word(tick_word());

    // One full trapezoid. With the ramp start at 1000 and a target 16 Hz above it
    // the ramp is 1001 ticks long: the rate steps up after 1000 ticks, holds, turns
    // down once fewer than 1001 steps remain, steps down, reaches count zero, and
    // leaves the down phase one thousand ticks later.
    drain();
    write_limits(HIGH_HZ, 14'd1000);
    send_word(move_word(1016, 31'd2101));
    repeat (3105) send_word(tick_word());

    // Random moves under each register setting. Registers change only once the
    // pipeline has drained.
    for (int i = 0; i < NUM_SETTINGS; i++) begin
      drain();
      write_limits(limit_max[i], limit_start[i]);
      run_moves(WORDS_PER_SETTING, limit_start[i]);
    end

    drain();
    if (mismatches == 0) begin
      $display("stepper_rate_ramp_controller_tb: done, clean");
    end else begin
      $display("stepper_rate_ramp_controller_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/srrc_pkg.sv
src/stepper_rate_ramp_controller.sv
tb/ramp_status_checker.sv
tb/stepper_rate_ramp_controller_tb.sv
